// ----- src/irfb_pkg.sv -----
// Package: shared constants, types and helper functions for the rotation frame buffer.
`timescale 1ns / 1ps
`default_nettype none
package irfb_pkg;

  localparam int MAX_DIM      = 64;
  localparam int MAX_CHANNELS = 4;
  localparam int DEPTH        = MAX_DIM * MAX_DIM;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int DIM_W        = $clog2(MAX_DIM + 1);
  localparam int POS_W        = $clog2(MAX_DIM);
  localparam int PIX_W        = 32;
  localparam int CH_W         = 3;
  localparam int MODE_W       = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_CW  = 2'd0,
    MODE_CCW = 2'd1,
    MODE_180 = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_CHANNELS = 2'd2,
    CFG_MODE     = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    ACT_STORE = 1'b0,
    ACT_FETCH = 1'b1
  } action_e;

  typedef struct packed {
    action_e            action;
    logic [PIX_W-1:0]   pixel_in;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_out;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [CH_W-1:0]    channels;
    logic [MODE_W-1:0]  mode;
  } cfg_t;

  typedef struct packed {
    logic               wr_en;
    logic               rd_en;
    logic [ADDR_W-1:0]  addr;
    logic [PIX_W-1:0]   wr_data;
  } mem_req_t;

  // Zero acts as one, anything above MAX_DIM acts as MAX_DIM.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  // Byte enable mask for the valid channels, clamped to 1..MAX_CHANNELS.
  function automatic logic [PIX_W-1:0] channel_mask(input logic [CH_W-1:0] ch);
    logic [CH_W-1:0]  n;
    logic [PIX_W-1:0] m;
    n = ch;
    if (ch == '0) begin
      n = CH_W'(1);
    end else if (ch > CH_W'(MAX_CHANNELS)) begin
      n = CH_W'(MAX_CHANNELS);
    end
    for (int k = 0; k < PIX_W / 8; k++) begin
      m[k*8 +: 8] = (CH_W'(k) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ----- src/irfb_addr_gen.sv -----
// Address generator: load counter, rotated fetch position and memory request.
`timescale 1ns / 1ps
`default_nettype none
module irfb_addr_gen (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start_i,
  input  irfb_pkg::in_word_t       in_word_i,
  input  irfb_pkg::cfg_t           cfg_i,
  output irfb_pkg::mem_req_t       req_o,
  output logic                     last_o
);
  import irfb_pkg::*;

  logic [CNT_W-1:0]       load_count_q, load_count_d;
  logic [POS_W-1:0]       out_row_q, out_row_d;
  logic [POS_W-1:0]       out_col_q, out_col_d;

  logic [DIM_W-1:0]       w, h, ow, oh, ow_m1, oh_m1;
  logic [2*DIM_W-1:0]     total;
  logic [POS_W-1:0]       r, c, sr, sc;
  logic [POS_W+DIM_W-1:0] prod, idx;
  logic                   col_end, row_end;

  always_comb begin
    w     = clamp_dim(cfg_i.width);
    h     = clamp_dim(cfg_i.height);
    total = {{DIM_W{1'b0}}, w} * {{DIM_W{1'b0}}, h};

    if (cfg_i.mode == MODE_CW || cfg_i.mode == MODE_CCW) begin
      ow = h;
      oh = w;
    end else begin
      ow = w;
      oh = h;
    end
    ow_m1 = ow - DIM_W'(1);
    oh_m1 = oh - DIM_W'(1);

    // Clamp the position into the current rotated frame for addressing.
    r = ({1'b0, out_row_q} < oh) ? out_row_q : oh_m1[POS_W-1:0];
    c = ({1'b0, out_col_q} < ow) ? out_col_q : ow_m1[POS_W-1:0];

    case (cfg_i.mode)
      MODE_CW: begin
        sr = POS_W'(h - DIM_W'(1) - {1'b0, c});
        sc = r;
      end
      MODE_CCW: begin
        sr = c;
        sc = POS_W'(w - DIM_W'(1) - {1'b0, r});
      end
      default: begin
        sr = POS_W'(h - DIM_W'(1) - {1'b0, r});
        sc = POS_W'(w - DIM_W'(1) - {1'b0, c});
      end
    endcase

    prod = {{DIM_W{1'b0}}, sr} * {{POS_W{1'b0}}, w};
    idx  = prod + {{DIM_W{1'b0}}, sc};

    col_end = ({1'b0, out_col_q} >= ow_m1);
    row_end = ({1'b0, out_row_q} >= oh_m1);

    req_o.wr_en   = 1'b0;
    req_o.rd_en   = 1'b0;
    req_o.addr    = idx[ADDR_W-1:0];
    req_o.wr_data = in_word_i.pixel_in;
    last_o        = 1'b0;

    load_count_d = load_count_q;
    out_row_d    = out_row_q;
    out_col_d    = out_col_q;

    if (start_i) begin
      if (in_word_i.action == ACT_STORE) begin
        // Drop stores once the frame is full.
        if ({1'b0, load_count_q} < total) begin
          req_o.wr_en  = 1'b1;
          req_o.addr   = load_count_q[ADDR_W-1:0];
          load_count_d = load_count_q + CNT_W'(1);
        end
      end else begin
        req_o.rd_en = 1'b1;
        if (col_end) begin
          if (row_end) begin
            last_o       = 1'b1;
            out_row_d    = '0;
            out_col_d    = '0;
            load_count_d = '0;
          end else begin
            out_col_d = '0;
            out_row_d = out_row_q + POS_W'(1);
          end
        end else begin
          out_col_d = out_col_q + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_count_q <= '0;
      out_row_q    <= '0;
      out_col_q    <= '0;
    end else begin
      load_count_q <= load_count_d;
      out_row_q    <= out_row_d;
      out_col_q    <= out_col_d;
    end
  end

endmodule
`default_nettype wire

// ----- src/irfb_frame_mem.sv -----
// Frame memory: single-port synchronous pixel store with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module irfb_frame_mem (
  input  wire                          clk_i,
  input  irfb_pkg::mem_req_t           req_i,
  output logic [irfb_pkg::PIX_W-1:0]   rd_data_o
);
  import irfb_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_o <= mem[req_i.addr];
    end
  end

endmodule
`default_nettype wire

// ----- src/image_rotate_frame_buffer_unit.sv -----
// Top level: rotation frame buffer with configuration registers and result stage.
`timescale 1ns / 1ps
`default_nettype none
// The block takes one word per cycle and busy_o stays low: a store writes the
// frame memory in the cycle it is accepted, a fetch reads it in that cycle and
// its result appears on out_word_o with done_o high in the next cycle, as the
// read port of the frame memory is registered. Results are shown for exactly
// one cycle and cannot be held off, so sample out_word_o whenever done_o is
// high. Stores past width*height are dropped; the fetch that returns the final
// rotated pixel raises last and rewinds both the store counter and the fetch
// position. Fetch only pixels already stored: memory contents are undefined
// after reset. Write configuration only while no fetch result is pending.
module image_rotate_frame_buffer_unit (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  start_i,
  output logic                                 busy_o,
  input  irfb_pkg::in_word_t                   in_word_i,
  output logic                                 done_o,
  output irfb_pkg::out_word_t                  out_word_o,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire [irfb_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire [irfb_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import irfb_pkg::*;

  cfg_t               cfg_q, cfg_d;
  mem_req_t           req;
  logic               fetch_last;
  logic [PIX_W-1:0]   rd_data;
  logic               valid_q;
  logic               last_q;
  logic [PIX_W-1:0]   mask_q;
  logic               accept;

  // Every cycle takes a word; the receiver cannot stall.
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  // Configuration write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:    cfg_d.width    = cfg_data_i[DIM_W-1:0];
        CFG_HEIGHT:   cfg_d.height   = cfg_data_i[DIM_W-1:0];
        CFG_CHANNELS: cfg_d.channels = cfg_data_i[CH_W-1:0];
        CFG_MODE:     cfg_d.mode     = cfg_data_i[MODE_W-1:0];
        default:      cfg_d          = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width    <= DIM_W'(1);
      cfg_q.height   <= DIM_W'(1);
      cfg_q.channels <= CH_W'(1);
      cfg_q.mode     <= MODE_CW;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  irfb_addr_gen u_addr_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .in_word_i (in_word_i),
    .cfg_i     (cfg_q),
    .req_o     (req),
    .last_o    (fetch_last)
  );

  irfb_frame_mem u_frame_mem (
    .clk_i     (clk_i),
    .req_i     (req),
    .rd_data_o (rd_data)
  );

  // Result stage: advance the strobe alongside the memory read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= req.rd_en;
    end
  end

  // Hold last and the channel mask with the read so they line up with its data.
  always_ff @(posedge clk_i) begin
    if (req.rd_en) begin
      last_q <= fetch_last;
      mask_q <= channel_mask(cfg_q.channels);
    end
  end

  assign done_o               = valid_q;
  assign out_word_o.pixel_out = rd_data & mask_q;
  assign out_word_o.last      = last_q;

endmodule
`default_nettype wire

// ----- bench/image_rotate_frame_buffer_unit_tb.sv -----
// Self-checking testbench for the rotation frame buffer: directed script, then random frames.
`timescale 1ns / 1ps
module image_rotate_frame_buffer_unit_tb;
  import irfb_pkg::*;

  localparam int STALL_LIMIT  = 2000;  // cycles with no handshake before giving up
  localparam int RANDOM_WORDS = 850;
  localparam int DRAIN_CYCLES = 4;     // covers the registered read, plus margin

  // One row of the directed script: either a register write or a word.
  typedef struct {
    bit               is_cfg;
    cfg_idx_e         reg_idx;
    logic [6:0]       reg_data;
    action_e          act;
    logic [PIX_W-1:0] pix;
    bit               typed;
    out_word_t        want;
  } script_row_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start_i     = 1'b0;
  in_word_t              in_word_i   = '0;
  logic                  cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  busy_o;
  logic                  done_o;
  out_word_t             out_word_o;
  logic                  cfg_ready_o;

  image_rotate_frame_buffer_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .in_word_i   (in_word_i),
    .done_o      (done_o),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the block: frame contents, counters and registers.
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0]  frame_copy [DEPTH];
  bit                stored     [DEPTH];  // entry written since reset
  int unsigned       load_cnt;
  int unsigned       out_row;
  int unsigned       out_col;
  logic [DIM_W-1:0]  width_reg;
  logic [DIM_W-1:0]  height_reg;
  logic [CH_W-1:0]   chan_reg;
  logic [MODE_W-1:0] mode_reg;

  out_word_t   pending_pixels [$];  // fetch results still to come, oldest first
  int unsigned fail_count;
  int unsigned items_done;
  int unsigned idle_pct;
  int unsigned quiet_cycles;

  // Zero acts as one, anything past the frame limit acts as the limit.
  function automatic int unsigned dim_of(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  function automatic logic [PIX_W-1:0] lane_mask();
    int unsigned n;
    n = (chan_reg == 0) ? 1 : (chan_reg > MAX_CHANNELS) ? MAX_CHANNELS : 32'(chan_reg);
    if (n >= 4) return '1;
    return (32'h1 << (8 * n)) - 32'h1;
  endfunction

  // Both 90 degree modes swap the axes; 180 and the unused code keep them.
  function automatic void rotated_size(output int unsigned ow, output int unsigned oh);
    if (mode_reg == MODE_CW || mode_reg == MODE_CCW) begin
      ow = dim_of(height_reg);
      oh = dim_of(width_reg);
    end else begin
      ow = dim_of(width_reg);
      oh = dim_of(height_reg);
    end
  endfunction

  // Source entry behind the next rotated pixel; clamp a stale position.
  function automatic int unsigned fetch_index();
    int unsigned w, h, ow, oh, r, c, sr, sc;
    w = dim_of(width_reg);
    h = dim_of(height_reg);
    rotated_size(ow, oh);
    r = (out_row < oh) ? out_row : oh - 1;
    c = (out_col < ow) ? out_col : ow - 1;
    if (mode_reg == MODE_CW) begin
      sr = h - 1 - c;
      sc = r;
    end else if (mode_reg == MODE_CCW) begin
      sr = c;
      sc = w - 1 - r;
    end else begin
      sr = h - 1 - r;
      sc = w - 1 - c;
    end
    return sr * w + sc;
  endfunction

  // Advance the shadow by one accepted word; report the result it causes.
  function automatic void frame_step(input in_word_t word, output bit produced,
                                     output out_word_t res, output bit effective);
    int unsigned total, ow, oh;
    total    = dim_of(width_reg) * dim_of(height_reg);
    produced = 1'b0;
    res      = '0;
    if (word.action == ACT_STORE) begin
      // Drop stores once the frame is full.
      effective = (load_cnt < total);
      if (effective) begin
        frame_copy[load_cnt] = word.pixel_in;
        stored[load_cnt]     = 1'b1;
        load_cnt++;
      end
      return;
    end
    effective     = 1'b1;
    produced      = 1'b1;
    res.pixel_out = frame_copy[fetch_index()] & lane_mask();
    rotated_size(ow, oh);
    if (out_col >= ow - 1) begin
      if (out_row >= oh - 1) begin
        // Final pixel: rewind the fetch position and the store counter.
        res.last = 1'b1;
        out_row  = 0;
        out_col  = 0;
        load_cnt = 0;
      end else begin
        out_col = 0;
        out_row++;
      end
    end else begin
      out_col++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. All inputs change by nonblocking assignment right after a rising
  // edge; acceptance is judged on the values seen at the edge.
  // ---------------------------------------------------------------------------
  task automatic push_word(input action_e act, input logic [PIX_W-1:0] pix,
                           input bit typed, input out_word_t want);
    in_word_t  word;
    bit        produced, effective;
    out_word_t res;
    word.action   = act;
    word.pixel_in = pix;
    in_word_i <= word;
    start_i   <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    frame_step(word, produced, res, effective);
    if (produced) pending_pixels.push_back(typed ? want : res);
    if (effective) items_done++;
    // Hold start low for a random gap; keep it high when no gap is drawn.
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Write one register once every fetch result is back and the pipe is empty.
  task automatic write_reg(input cfg_idx_e idx, input logic [6:0] data);
    start_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_WIDTH:    width_reg  = data;
      CFG_HEIGHT:   height_reg = data;
      CFG_CHANNELS: chan_reg   = data[CH_W-1:0];
      CFG_MODE:     mode_reg   = data[MODE_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Never fetch an entry that was not written since reset: store instead.
  task automatic drive_random(input action_e act);
    action_e a;
    a = act;
    if (a == ACT_FETCH && !stored[fetch_index()]) a = ACT_STORE;
    push_word(a, $urandom(), 1'b0, '0);
  endtask

  // Empty row: a store of zero, nothing typed in.
  function automatic script_row_t row_blank();
    script_row_t r;
    r = '{is_cfg: 1'b0, reg_idx: CFG_WIDTH, reg_data: '0, act: ACT_STORE,
          pix: '0, typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic script_row_t row_reg(input cfg_idx_e idx, input logic [6:0] data);
    script_row_t r;
    r          = row_blank();
    r.is_cfg   = 1'b1;
    r.reg_idx  = idx;
    r.reg_data = data;
    return r;
  endfunction

  function automatic script_row_t row_store(input logic [PIX_W-1:0] pix);
    script_row_t r;
    r     = row_blank();
    r.act = ACT_STORE;
    r.pix = pix;
    return r;
  endfunction

  // Fetch checked against the shadow.
  function automatic script_row_t row_fetch();
    script_row_t r;
    r     = row_blank();
    r.act = ACT_FETCH;
    return r;
  endfunction

  // Fetch with its result written out by hand.
  function automatic script_row_t row_fetch_is(input logic [PIX_W-1:0] pix, input bit last);
    script_row_t r;
    r                = row_fetch();
    r.typed          = 1'b1;
    r.want.pixel_out = pix;
    r.want.last      = last;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, result checker and watchdog.
  // ---------------------------------------------------------------------------
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [PIX_W-1:0] exp_v,
                                 input logic [PIX_W-1:0] got_v);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_v, got_v);
  endtask

  // Results cannot be held off: sample every cycle that done is high.
  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni && done_o) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected result, pixel_out", '0, out_word_o.pixel_out);
      end else begin
        exp_w = pending_pixels.pop_front();
        if (out_word_o.pixel_out !== exp_w.pixel_out)
          report_mismatch("pixel_out", exp_w.pixel_out, out_word_o.pixel_out);
        if (out_word_o.last !== exp_w.last)
          report_mismatch("last", exp_w.last, out_word_o.last);
      end
    end
  end

  // Stop a run that hangs: any word moved on any port resets the count.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin
    script_row_t script [$];
    int unsigned phase;
    int unsigned frame_px;
    logic [6:0]  wd, ht;

    fail_count   = 0;
    items_done   = 0;
    idle_pct     = 0;
    quiet_cycles = 0;
    load_cnt     = 0;
    out_row      = 0;
    out_col      = 0;
    width_reg    = 1;
    height_reg   = 1;
    chan_reg     = 1;
    mode_reg     = MODE_CW;
    foreach (stored[i]) stored[i] = 1'b0;

    // Directed script. Registers start at a 1x1 frame, one channel, clockwise.
    script = '{
      // Extremes of the pixel, one channel kept.
      row_store(32'hFFFF_FFFF), row_fetch_is(32'h0000_00FF, 1'b1),
      // Frame full: the second store is dropped.
      row_store(32'h0000_0000), row_store(32'h1234_5678), row_fetch_is(32'h0, 1'b1),
      // Channel count above the limit acts as four, zero acts as one.
      row_reg(CFG_CHANNELS, 7'd7), row_store(32'h8040_2010),
      row_fetch_is(32'h8040_2010, 1'b1),
      row_reg(CFG_CHANNELS, 7'd0), row_fetch_is(32'h0000_0010, 1'b1),
      row_reg(CFG_CHANNELS, 7'd3), row_fetch_is(32'h0040_2010, 1'b1),
      // 2x2 frame, unused mode code acts as 180.
      row_reg(CFG_WIDTH, 7'd2), row_reg(CFG_HEIGHT, 7'd2),
      row_reg(CFG_MODE, 7'd3), row_reg(CFG_CHANNELS, 7'd4),
      row_store(32'h1111_1111), row_store(32'h2222_2222),
      row_store(32'h3333_3333), row_store(32'h4444_4444),
      row_fetch_is(32'h4444_4444, 1'b0), row_fetch_is(32'h3333_3333, 1'b0),
      row_fetch_is(32'h2222_2222, 1'b0), row_fetch_is(32'h1111_1111, 1'b1),
      // Fetch the same frame again, before any reload, both 90 degree ways.
      row_reg(CFG_MODE, 7'(MODE_CW)),
      row_fetch(), row_fetch(), row_fetch(), row_fetch(),
      row_reg(CFG_MODE, 7'(MODE_CCW)),
      row_fetch(), row_fetch(), row_fetch(), row_fetch()
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].is_cfg)
        write_reg(script[i].reg_idx, script[i].reg_data);
      else
        push_word(script[i].act, script[i].pix, script[i].typed, script[i].want);
    end

    // Random frames. Rotate the idling style per phase: none, sender idle in
    // most cycles, sender idle now and then. Force the size extremes first.
    items_done = 0;
    phase      = 0;
    while (items_done < RANDOM_WORDS) begin
      idle_pct = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 83 : 20;
      case (phase)
        0: begin
          wd = 7'd127;  // past the limit, acts as a full row
          ht = 7'd1;
        end
        1: begin
          wd = 7'd1;
          ht = 7'd64;
        end
        2: begin
          wd = 7'd0;    // zero acts as one
          ht = 7'd0;
        end
        default: begin
          wd = 7'($urandom_range(1, 8));
          ht = 7'($urandom_range(0, 8));
        end
      endcase
      write_reg(CFG_WIDTH, wd);
      write_reg(CFG_HEIGHT, ht);
      write_reg(CFG_CHANNELS, 7'($urandom_range(0, 127)));
      write_reg(CFG_MODE, 7'($urandom_range(0, 127)));
      frame_px = dim_of(width_reg) * dim_of(height_reg);
      if ($urandom_range(9) < 7) begin
        // Well-formed frame, sometimes overfilled, then read out whole.
        repeat (frame_px + $urandom_range(0, 2)) drive_random(ACT_STORE);
        repeat (frame_px) drive_random(ACT_FETCH);
      end else begin
        // Noise: broken frames, partial loads, stale fetch positions.
        repeat ($urandom_range(10, 40)) drive_random(action_e'($urandom_range(0, 1)));
      end
      phase++;
    end

    // Drain: wait for every result, then let the pipe settle.
    start_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
